FILE: rtl/core/vlcd_pkg.sv
// Shared types, constants and sequence table for the voltmeter display driver.
// No dependencies; used by vlcd_digits and voltmeter_lcd_nibble_driver_core.
`default_nettype none

package vlcd_pkg;

  localparam int unsigned SeqLen   = 35;
  localparam int unsigned StepW    = 6;
  localparam int unsigned CodeW    = 7;
  localparam int unsigned WaitW    = 20;
  localparam int unsigned NibW     = 4;
  localparam int unsigned HundW    = 9;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned NumRegs  = 5;
  localparam int unsigned HundScale = 500;

  typedef logic [StepW-1:0] step_t;
  typedef logic [CodeW-1:0] code_t;

  // Step code classes
  localparam code_t OpData  = 7'h10;
  localparam code_t OpDigit = 7'h20;
  localparam code_t OpWait  = 7'h40;

  typedef enum logic [CfgIdxW-1:0] {
    REG_STARTUP  = 3'd0,
    REG_COMMAND  = 3'd1,
    REG_CLEAR    = 3'd2,
    REG_PRE_DATA = 3'd3,
    REG_REFRESH  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [NibW-1:0] d0;  // volts
    logic [NibW-1:0] d1;  // tenths
    logic [NibW-1:0] d2;  // hundredths
  } digits_t;

  // 0x0n command nibble, 0x1n data nibble, 0x2k low nibble of digit k, 0x4r wait on reg r
  function automatic code_t seq_code(step_t s);
    code_t c;
    case (s)
      6'd0:  c = 7'h00;
      6'd1:  c = 7'h40;
      6'd2:  c = 7'h03;
      6'd3:  c = 7'h41;
      6'd4:  c = 7'h03;
      6'd5:  c = 7'h41;
      6'd6:  c = 7'h02;
      6'd7:  c = 7'h41;
      6'd8:  c = 7'h02;
      6'd9:  c = 7'h08;
      6'd10: c = 7'h41;
      6'd11: c = 7'h00;
      6'd12: c = 7'h0C;
      6'd13: c = 7'h41;
      6'd14: c = 7'h00;
      6'd15: c = 7'h01;
      6'd16: c = 7'h41;
      6'd17: c = 7'h42;
      6'd18: c = 7'h00;
      6'd19: c = 7'h06;
      6'd20: c = 7'h41;
      6'd21: c = 7'h43;
      6'd22: c = 7'h13;
      6'd23: c = 7'h20;
      6'd24: c = 7'h41;
      6'd25: c = 7'h12;
      6'd26: c = 7'h1E;
      6'd27: c = 7'h41;
      6'd28: c = 7'h13;
      6'd29: c = 7'h21;
      6'd30: c = 7'h41;
      6'd31: c = 7'h13;
      6'd32: c = 7'h22;
      6'd33: c = 7'h41;
      6'd34: c = 7'h44;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  // Map a wait code to its register; unused codes fall back to the refresh register
  function automatic reg_idx_t wait_reg_of(code_t c);
    reg_idx_t r;
    case (c[CfgIdxW-1:0])
      REG_STARTUP:  r = REG_STARTUP;
      REG_COMMAND:  r = REG_COMMAND;
      REG_CLEAR:    r = REG_CLEAR;
      REG_PRE_DATA: r = REG_PRE_DATA;
      default:      r = REG_REFRESH;
    endcase
    return r;
  endfunction

  // Skip waits whose register is zero; the table never has more than two waits in a row
  function automatic step_t skip_zero_waits(step_t s, logic [NumRegs-1:0] zero_reg);
    step_t t;
    code_t c;
    t = s;
    for (int i = 0; i < 2; i++) begin
      c = seq_code(t);
      if ((32'(t) < SeqLen) && ((c & OpWait) != '0) && zero_reg[wait_reg_of(c)]) begin
        t = t + step_t'(1);
      end
    end
    return t;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/vlcd_digits.sv
// Registered split of a hundredths-of-a-volt value (below 500) into three decimal digits.
// Depends on vlcd_pkg for widths and the digit struct.
`default_nettype none

module vlcd_digits (
  input  wire logic                       clk,
  input  wire logic [vlcd_pkg::HundW-1:0] hundredths,
  output vlcd_pkg::digits_t               digits
);

  logic [14:0] prod_q;     // hundredths * 41, top bits give /100
  logic [2:0]  q100;
  logic [8:0]  hund_sub;
  logic [6:0]  rem100;
  logic [14:0] prod_t;     // rem * 205, top bits give /10
  logic [3:0]  tens;
  logic [6:0]  ones;
  vlcd_pkg::digits_t digits_next;

  always_comb begin
    prod_q   = 15'(hundredths) * 15'd41;
    q100     = prod_q[14:12];
    hund_sub = 9'(q100) * 9'd100;
    rem100   = 7'(hundredths - hund_sub);
    prod_t   = 15'(rem100) * 15'd205;
    tens     = prod_t[14:11];
    ones     = rem100 - 7'(7'(tens) * 7'd10);
    digits_next.d0 = 4'(q100);
    digits_next.d1 = tens;
    digits_next.d2 = ones[3:0];
  end

  always_ff @(posedge clk) begin
    digits <= digits_next;
  end

endmodule

`default_nettype wire

FILE: rtl/core/voltmeter_lcd_nibble_driver_core.sv
// Voltmeter character display driver, 4-bit mode; one request per tick, one result each.
// Each result is registered as its request is taken and is offered in the next cycle.
// Throughput: one request per cycle while m_tready is high; the output register frees as its result is taken.
// Reset: wait registers return to their defaults, the sequencer goes idle, lines go to zero.
// Depends on vlcd_pkg and vlcd_digits.
`default_nettype none

module voltmeter_lcd_nibble_driver_core #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,   // [SAMPLE_BITS-1:0] sample
  input  wire logic                                 s_tuser,   // [0] sample_valid
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic [7:0]                                m_tdata,   // [3:0] lcd_nibble, [4] lcd_en,
                                                               // [5] busy_res
  output logic                                      m_tuser,   // [0] lcd_rs
  input  wire logic                                 cfg_wen,
  input  wire logic [vlcd_pkg::CfgIdxW-1:0]         cfg_index,
  input  wire logic [vlcd_pkg::CfgDataW-1:0]        cfg_data
);

  localparam int unsigned ProdW = SAMPLE_BITS + vlcd_pkg::HundW;

  // Wait registers
  logic [15:0] startup_wait;
  logic [11:0] command_wait;
  logic [15:0] clear_wait;
  logic [15:0] pre_data_wait;
  logic [19:0] refresh_wait;

  // Sequencer state
  vlcd_pkg::step_t               step_index, step_index_next;
  logic [vlcd_pkg::WaitW-1:0]    wait_count, wait_count_next;
  logic                          strobe_phase, strobe_phase_next;
  logic [vlcd_pkg::HundW-1:0]    hundredths, hundredths_next;
  logic [vlcd_pkg::NibW-1:0]     nibble_out, nibble_out_next;
  logic                          select_out, select_out_next;
  logic                          en_out, en_out_next;
  logic                          busy_out, busy_out_next;

  logic                          in_acc;
  logic                          idle;
  vlcd_pkg::code_t               code;
  vlcd_pkg::code_t               entry_code;
  vlcd_pkg::step_t               entry_start;
  vlcd_pkg::step_t               entry;
  logic                          do_enter;
  logic [vlcd_pkg::NumRegs-1:0]  zero_reg;
  logic [vlcd_pkg::WaitW-1:0]    entry_wait;
  logic [vlcd_pkg::WaitW-1:0]    wait_dec;
  logic [ProdW-1:0]              prod;
  vlcd_pkg::digits_t             digits;
  logic [vlcd_pkg::NibW-1:0]     digit_sel;

  vlcd_digits u_digits (
    .clk        (clk),
    .hundredths (hundredths),
    .digits     (digits)
  );

  assign s_tready = !m_tvalid || m_tready;
  assign in_acc   = s_tvalid && s_tready;
  assign m_tdata  = {2'b00, busy_out, en_out, nibble_out};
  assign m_tuser  = select_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_acc) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      startup_wait  <= 16'd40000;
      command_wait  <= 12'd100;
      clear_wait    <= 16'd5000;
      pre_data_wait <= 16'd2000;
      refresh_wait  <= 20'd100000;
    end else if (cfg_wen) begin
      case (cfg_index)
        vlcd_pkg::REG_STARTUP:  startup_wait  <= cfg_data[15:0];
        vlcd_pkg::REG_COMMAND:  command_wait  <= cfg_data[11:0];
        vlcd_pkg::REG_CLEAR:    clear_wait    <= cfg_data[15:0];
        vlcd_pkg::REG_PRE_DATA: pre_data_wait <= cfg_data[15:0];
        vlcd_pkg::REG_REFRESH:  refresh_wait  <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  assign zero_reg = {refresh_wait == '0, pre_data_wait == '0, clear_wait == '0,
                     command_wait == '0, startup_wait == '0};

  assign idle = (step_index == '0) || (32'(step_index) >= vlcd_pkg::SeqLen);
  assign code = vlcd_pkg::seq_code(step_index);
  assign prod = ProdW'(s_tdata[SAMPLE_BITS-1:0]) * ProdW'(vlcd_pkg::HundScale);
  assign wait_dec = (wait_count != '0) ? wait_count - 20'd1 : wait_count;

  // Next step after the current one, with zero-length waits skipped
  assign entry_start = idle ? vlcd_pkg::step_t'(1) : step_index + vlcd_pkg::step_t'(1);
  assign entry       = vlcd_pkg::skip_zero_waits(entry_start, zero_reg);
  assign entry_code  = vlcd_pkg::seq_code(entry);

  always_comb begin
    case (vlcd_pkg::wait_reg_of(entry_code))
      vlcd_pkg::REG_STARTUP:  entry_wait = 20'(startup_wait);
      vlcd_pkg::REG_COMMAND:  entry_wait = 20'(command_wait);
      vlcd_pkg::REG_CLEAR:    entry_wait = 20'(clear_wait);
      vlcd_pkg::REG_PRE_DATA: entry_wait = 20'(pre_data_wait);
      default:                entry_wait = refresh_wait;
    endcase
  end

  always_comb begin
    case (code[1:0])
      2'd0:    digit_sel = digits.d0;
      2'd1:    digit_sel = digits.d1;
      default: digit_sel = digits.d2;
    endcase
  end

  always_comb begin
    step_index_next   = step_index;
    wait_count_next   = wait_count;
    strobe_phase_next = strobe_phase;
    hundredths_next   = hundredths;
    nibble_out_next   = nibble_out;
    select_out_next   = select_out;
    en_out_next       = 1'b0;
    busy_out_next     = 1'b0;
    do_enter          = 1'b0;

    if (idle) begin
      step_index_next = '0;
      if (s_tuser) begin
        hundredths_next = prod[SAMPLE_BITS +: vlcd_pkg::HundW];
        busy_out_next   = 1'b1;
        do_enter        = 1'b1;
      end
    end else begin
      busy_out_next = 1'b1;
      if ((code & vlcd_pkg::OpWait) != '0) begin
        wait_count_next = wait_dec;
        do_enter        = (wait_dec == '0);
      end else if (!strobe_phase) begin
        // set up the lines; strobe on the next tick
        if ((code & vlcd_pkg::OpDigit) != '0) begin
          nibble_out_next = digit_sel;
          select_out_next = 1'b1;
        end else begin
          nibble_out_next = code[vlcd_pkg::NibW-1:0];
          select_out_next = (code & vlcd_pkg::OpData) != '0;
        end
        strobe_phase_next = 1'b1;
      end else begin
        en_out_next       = 1'b1;
        strobe_phase_next = 1'b0;
        do_enter          = 1'b1;
      end
    end

    if (do_enter) begin
      if (32'(entry) >= vlcd_pkg::SeqLen) begin
        step_index_next   = '0;
        strobe_phase_next = 1'b0;
        wait_count_next   = '0;
      end else if ((entry_code & vlcd_pkg::OpWait) != '0) begin
        step_index_next = entry;
        wait_count_next = entry_wait;
      end else begin
        step_index_next   = entry;
        strobe_phase_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_index   <= '0;
      wait_count   <= '0;
      strobe_phase <= 1'b0;
      nibble_out   <= '0;
      select_out   <= 1'b0;
      en_out       <= 1'b0;
      busy_out     <= 1'b0;
    end else if (in_acc) begin
      step_index   <= step_index_next;
      wait_count   <= wait_count_next;
      strobe_phase <= strobe_phase_next;
      nibble_out   <= nibble_out_next;
      select_out   <= select_out_next;
      en_out       <= en_out_next;
      busy_out     <= busy_out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      hundredths <= hundredths_next;
    end
  end

endmodule

`default_nettype wire

FILE: tb/tb_voltmeter_lcd_nibble_driver_core.sv
// Self-checking testbench for voltmeter_lcd_nibble_driver_core: drives display ticks and
// checks each display line result against a 4-bit sequencer model or a typed row's line.
// Depends on vlcd_pkg and the driver core RTL.
`default_nettype none

module tb_voltmeter_lcd_nibble_driver_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SAMPLE_BITS = 10;
  localparam int unsigned TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned VOLT_SCALE  = 500;
  localparam int unsigned SEQ_END     = 35;

  // display commands and characters sent by the init and digit sequence
  localparam logic [3:0] LCD_WAKE       = 4'h3;
  localparam logic [3:0] LCD_NIB_MODE   = 4'h2;
  localparam logic [7:0] LCD_FUNC_SET   = 8'h28;
  localparam logic [7:0] LCD_DISPLAY_ON = 8'h0C;
  localparam logic [7:0] LCD_CLEAR      = 8'h01;
  localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] ASCII_ZERO     = 8'h30;
  localparam logic [7:0] ASCII_POINT    = 8'h2E;

  localparam logic [3:0] DIGIT_VOLTS      = 4'd0;
  localparam logic [3:0] DIGIT_TENTHS     = 4'd1;
  localparam logic [3:0] DIGIT_HUNDREDTHS = 4'd2;

  localparam logic [3:0] W_STARTUP  = 4'(vlcd_pkg::REG_STARTUP);
  localparam logic [3:0] W_COMMAND  = 4'(vlcd_pkg::REG_COMMAND);
  localparam logic [3:0] W_CLEAR    = 4'(vlcd_pkg::REG_CLEAR);
  localparam logic [3:0] W_PRE_DATA = 4'(vlcd_pkg::REG_PRE_DATA);
  localparam logic [3:0] W_REFRESH  = 4'(vlcd_pkg::REG_REFRESH);

  // indexes past the register file; writes there must be dropped
  localparam logic [2:0] REG_BEYOND = 3'd5;
  localparam logic [2:0] REG_TOP    = 3'd7;

  typedef enum logic [2:0] {OPK_IDLE, OPK_WAIT, OPK_CMD, OPK_CHAR, OPK_DIGIT} op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [3:0] arg;
  } seq_op_t;

  typedef struct packed {
    logic [3:0] nib;
    logic       rs;
    logic       en;
    logic       busy;
  } lcd_out_t;

  typedef struct packed {
    bit           is_cfg;
    logic [2:0]   idx;
    logic [19:0]  val;
    bit           sv;
    logic [15:0]  d;
    bit           typed;
    lcd_out_t     want;
  } stim_row_t;

  localparam lcd_out_t NO_LINE     = '0;
  localparam lcd_out_t IDLE_LINES  = '{4'h0, 1'b0, 1'b0, 1'b0};
  localparam lcd_out_t LATCH_LINES = '{4'h0, 1'b0, 1'b0, 1'b1};

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [TDATA_W-1:0]  s_tdata;
  logic                s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [7:0]          m_tdata;
  logic                m_tuser;
  logic                cfg_wen;
  logic [vlcd_pkg::CfgIdxW-1:0]  cfg_index;
  logic [vlcd_pkg::CfgDataW-1:0] cfg_data;

  voltmeter_lcd_nibble_driver_core #(.SAMPLE_BITS(SAMPLE_BITS)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // model state
  logic [19:0] wait_cfg [0:4];
  int unsigned seq_pos;
  int unsigned wait_left;
  bit          strobe_hi;
  logic [8:0]  centivolts;
  logic [3:0]  held_nib;
  logic        held_rs;

  lcd_out_t    pending_lines [$];
  int          mismatches;
  int          results_seen;
  bit          row_typed;
  lcd_out_t    row_want;
  bit          quiet;
  bit          held_long;

  stim_row_t dir_rows [27] = '{
    '{1'b1, vlcd_pkg::REG_STARTUP,  20'hF0004, 1'b0, 16'h0000, 1'b0, NO_LINE},
    '{1'b1, vlcd_pkg::REG_COMMAND,  20'hFF000, 1'b0, 16'h0000, 1'b0, NO_LINE},
    '{1'b1, vlcd_pkg::REG_CLEAR,    20'h00000, 1'b0, 16'h0000, 1'b0, NO_LINE},
    '{1'b1, vlcd_pkg::REG_PRE_DATA, 20'h00001, 1'b0, 16'h0000, 1'b0, NO_LINE},
    '{1'b1, vlcd_pkg::REG_REFRESH,  20'h00002, 1'b0, 16'h0000, 1'b0, NO_LINE},
    '{1'b1, REG_BEYOND,             20'hFFFFF, 1'b0, 16'h0000, 1'b0, NO_LINE},
    '{1'b1, REG_TOP,                20'h5A5A5, 1'b0, 16'h0000, 1'b0, NO_LINE},
    '{1'b0, 3'd0, 20'h0, 1'b0, 16'h0000, 1'b1, IDLE_LINES},
    '{1'b0, 3'd0, 20'h0, 1'b0, 16'hFFFF, 1'b1, IDLE_LINES},
    // zero sample with the unused upper bits set
    '{1'b0, 3'd0, 20'h0, 1'b1, 16'hFC00, 1'b1, LATCH_LINES},
    '{1'b0, 3'd0, 20'h0, 1'b1, 16'h03FF, 1'b0, NO_LINE},
    // rewrite the start-up wait while it is counting
    '{1'b1, vlcd_pkg::REG_STARTUP,  20'h00000, 1'b0, 16'h0000, 1'b0, NO_LINE},
    '{1'b0, 3'd0, 20'h0, 1'b0, 16'h0000, 1'b0, NO_LINE},
    '{1'b0, 3'd0, 20'h0, 1'b1, 16'hFFFF, 1'b0, NO_LINE},
    '{1'b0, 3'd0, 20'h0, 1'b0, 16'hAAAA, 1'b0, NO_LINE},
    '{1'b0, 3'd0, 20'h0, 1'b1, 16'h5555, 1'b0, NO_LINE},
    '{1'b0, 3'd0, 20'h0, 1'b0, 16'hFFFF, 1'b0, NO_LINE},
    '{1'b0, 3'd0, 20'h0, 1'b1, 16'h0200, 1'b0, NO_LINE},
    '{1'b0, 3'd0, 20'h0, 1'b0, 16'h0000, 1'b0, NO_LINE},
    '{1'b0, 3'd0, 20'h0, 1'b1, 16'h0001, 1'b0, NO_LINE},
    '{1'b0, 3'd0, 20'h0, 1'b0, 16'h8000, 1'b0, NO_LINE},
    '{1'b0, 3'd0, 20'h0, 1'b1, 16'h7FFF, 1'b0, NO_LINE},
    '{1'b0, 3'd0, 20'h0, 1'b0, 16'h1234, 1'b0, NO_LINE},
    '{1'b0, 3'd0, 20'h0, 1'b1, 16'h03FF, 1'b0, NO_LINE},
    '{1'b0, 3'd0, 20'h0, 1'b0, 16'h0000, 1'b0, NO_LINE},
    '{1'b0, 3'd0, 20'h0, 1'b1, 16'hFFFF, 1'b0, NO_LINE},
    '{1'b0, 3'd0, 20'h0, 1'b0, 16'h0155, 1'b0, NO_LINE}
  };

  always begin
    #10 clk = ~clk;
  end

  // step 8 shares its high nibble with the function-set command
  function automatic seq_op_t seq_op(int unsigned s);
    seq_op_t o;
    o = '{OPK_IDLE, 4'h0};
    case (s)
      1:                              o = '{OPK_WAIT, W_STARTUP};
      2, 4:                           o = '{OPK_CMD, LCD_WAKE};
      6, 8:                           o = '{OPK_CMD, LCD_NIB_MODE};
      3, 5, 7, 10, 13, 16, 20, 24, 27, 30, 33:
                                      o = '{OPK_WAIT, W_COMMAND};
      9:                              o = '{OPK_CMD, LCD_FUNC_SET[3:0]};
      11:                             o = '{OPK_CMD, LCD_DISPLAY_ON[7:4]};
      12:                             o = '{OPK_CMD, LCD_DISPLAY_ON[3:0]};
      14:                             o = '{OPK_CMD, LCD_CLEAR[7:4]};
      15:                             o = '{OPK_CMD, LCD_CLEAR[3:0]};
      17:                             o = '{OPK_WAIT, W_CLEAR};
      18:                             o = '{OPK_CMD, LCD_ENTRY_MODE[7:4]};
      19:                             o = '{OPK_CMD, LCD_ENTRY_MODE[3:0]};
      21:                             o = '{OPK_WAIT, W_PRE_DATA};
      22, 28, 31:                     o = '{OPK_CHAR, ASCII_ZERO[7:4]};
      23:                             o = '{OPK_DIGIT, DIGIT_VOLTS};
      25:                             o = '{OPK_CHAR, ASCII_POINT[7:4]};
      26:                             o = '{OPK_CHAR, ASCII_POINT[3:0]};
      29:                             o = '{OPK_DIGIT, DIGIT_TENTHS};
      32:                             o = '{OPK_DIGIT, DIGIT_HUNDREDTHS};
      34:                             o = '{OPK_WAIT, W_REFRESH};
      default:                        o = '{OPK_IDLE, 4'h0};
    endcase
    return o;
  endfunction

  function automatic logic [3:0] digit_of(logic [3:0] k);
    int unsigned h;
    h = centivolts % 1000;
    if (k == DIGIT_VOLTS) return 4'(h / 100);
    if (k == DIGIT_TENTHS) return 4'((h / 10) % 10);
    return 4'(h % 10);
  endfunction

  // land on step s, skipping waits whose register is zero
  function automatic void enter_step(int unsigned s);
    seq_op_t o;
    while (s < SEQ_END) begin
      o = seq_op(s);
      if (o.kind == OPK_WAIT) begin
        if (wait_cfg[o.arg] == 0) begin
          s++;
          continue;
        end
        seq_pos = s;
        wait_left = wait_cfg[o.arg];
        return;
      end
      seq_pos = s;
      strobe_hi = 1'b0;
      return;
    end
    seq_pos = 0;
    strobe_hi = 1'b0;
    wait_left = 0;
  endfunction

  function automatic lcd_out_t advance_display(bit sv, logic [TDATA_W-1:0] d);
    lcd_out_t r;
    seq_op_t  o;
    logic     en;
    logic     busy;
    en = 1'b0;
    busy = 1'b0;
    if (seq_pos == 0 || seq_pos >= SEQ_END) begin
      seq_pos = 0;
      if (sv) begin
        centivolts = 9'((32'(d[SAMPLE_BITS-1:0]) * VOLT_SCALE) >> SAMPLE_BITS);
        busy = 1'b1;
        enter_step(1);
      end
    end else begin
      o = seq_op(seq_pos);
      busy = 1'b1;
      if (o.kind == OPK_WAIT) begin
        if (wait_left > 0) wait_left--;
        if (wait_left == 0) enter_step(seq_pos + 1);
      end else if (!strobe_hi) begin
        if (o.kind == OPK_DIGIT) begin
          held_nib = digit_of(o.arg);
          held_rs = 1'b1;
        end else begin
          held_nib = o.arg;
          held_rs = (o.kind == OPK_CHAR);
        end
        strobe_hi = 1'b1;
      end else begin
        en = 1'b1;
        strobe_hi = 1'b0;
        enter_step(seq_pos + 1);
      end
    end
    r.nib = held_nib;
    r.rs = held_rs;
    r.en = en;
    r.busy = busy;
    return r;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [19:0] val);
    case (idx)
      vlcd_pkg::REG_STARTUP:  wait_cfg[W_STARTUP] = {4'h0, val[15:0]};
      vlcd_pkg::REG_COMMAND:  wait_cfg[W_COMMAND] = {8'h00, val[11:0]};
      vlcd_pkg::REG_CLEAR:    wait_cfg[W_CLEAR] = {4'h0, val[15:0]};
      vlcd_pkg::REG_PRE_DATA: wait_cfg[W_PRE_DATA] = {4'h0, val[15:0]};
      vlcd_pkg::REG_REFRESH:  wait_cfg[W_REFRESH] = val;
      default: ;
    endcase
  endfunction

  task automatic report_field(input string what, input logic [7:0] want, input logic [7:0] got);
    $display("%0t ns: %s expected %0h actual %0h", $time, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    lcd_out_t pred;
    lcd_out_t want;
    lcd_out_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        pred = advance_display(s_tuser, s_tdata);
        pending_lines.push_back(row_typed ? row_want : pred);
      end
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[3:0], m_tuser, m_tdata[4], m_tdata[5]};
        results_seen++;
        if (pending_lines.size() == 0) begin
          report_field("unexpected result", 8'h00, 8'(got));
        end else begin
          want = pending_lines.pop_front();
          if (got.nib !== want.nib) report_field("lcd_nibble", 8'(want.nib), 8'(got.nib));
          if (got.rs !== want.rs) report_field("lcd_rs", 8'(want.rs), 8'(got.rs));
          if (got.en !== want.en) report_field("lcd_en", 8'(want.en), 8'(got.en));
          if (got.busy !== want.busy) report_field("busy_res", 8'(want.busy), 8'(got.busy));
        end
      end
      if (cfg_wen) apply_reg(cfg_index, cfg_data);
    end
  end

  task automatic send_tick(input bit sv, input logic [TDATA_W-1:0] d);
    s_tvalid = 1'b1;
    s_tuser = sv;
    s_tdata = d;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // drain all results, then write one register
  task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
    s_tvalid = 1'b0;
    while (pending_lines.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_wen = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_wen = 1'b0;
  endtask

  task automatic write_all(input logic [19:0] st, input logic [19:0] cm, input logic [19:0] cl,
                           input logic [19:0] pd, input logic [19:0] rf);
    write_reg(vlcd_pkg::REG_STARTUP, st);
    write_reg(vlcd_pkg::REG_COMMAND, cm);
    write_reg(vlcd_pkg::REG_CLEAR, cl);
    write_reg(vlcd_pkg::REG_PRE_DATA, pd);
    write_reg(vlcd_pkg::REG_REFRESH, rf);
  endtask

  task automatic run_ticks(input int n);
    bit                 sv;
    logic [TDATA_W-1:0] d;
    bit                 tx_bursty;
    tx_bursty = 1'b1;
    for (int i = 0; i < n; i++) begin
      // latch often when idle so most ticks land inside a running sequence
      sv = (seq_pos == 0) ? ($urandom_range(0, 3) != 0) : 1'($urandom_range(0, 1));
      d = TDATA_W'($urandom);
      case ($urandom_range(0, 7))
        0: d[SAMPLE_BITS-1:0] = '0;
        1: d[SAMPLE_BITS-1:0] = '1;
        default: ;
      endcase
      if (!quiet && tx_bursty && $urandom_range(0, 4) == 0) begin
        s_tvalid = 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      if ($urandom_range(0, 39) == 0) tx_bursty = !tx_bursty;
      send_tick(sv, d);
    end
    s_tvalid = 1'b0;
  endtask

  initial begin
    bit rx_bursty;
    rx_bursty = 1'b1;
    m_tready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (!held_long && results_seen >= 150) begin
        // long hold-off while the sender keeps offering
        m_tready = 1'b0;
        repeat (300) @(negedge clk);
        held_long = 1'b1;
      end else if (!quiet && rx_bursty && $urandom_range(0, 5) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end else begin
        m_tready = 1'b1;
        @(negedge clk);
      end
      if ($urandom_range(0, 63) == 0) rx_bursty = !rx_bursty;
    end
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = 1'b0;
    s_tdata = '0;
    cfg_wen = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    wait_cfg[W_STARTUP] = 20'd40000;
    wait_cfg[W_COMMAND] = 20'd100;
    wait_cfg[W_CLEAR] = 20'd5000;
    wait_cfg[W_PRE_DATA] = 20'd2000;
    wait_cfg[W_REFRESH] = 20'd100000;
    seq_pos = 0;
    wait_left = 0;
    strobe_hi = 1'b0;
    centivolts = '0;
    held_nib = '0;
    held_rs = 1'b0;
    mismatches = 0;
    results_seen = 0;
    row_typed = 1'b0;
    row_want = NO_LINE;
    quiet = 1'b0;
    held_long = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        row_typed = dir_rows[i].typed;
        row_want = dir_rows[i].want;
        send_tick(dir_rows[i].sv, dir_rows[i].d);
      end
    end
    row_typed = 1'b0;
    s_tvalid = 1'b0;

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: write_all(20'($urandom_range(0, 3)), 20'($urandom_range(0, 2)),
                     20'($urandom_range(0, 3)), 20'($urandom_range(0, 3)),
                     20'($urandom_range(0, 5)));
        1: write_all('0, '0, '0, '0, '0);
        2: write_all(20'($urandom_range(1, 4)), 20'($urandom_range(1, 3)),
                     20'($urandom_range(1, 6)), 20'($urandom_range(1, 4)),
                     20'($urandom_range(1, 9)));
        3: begin
          // upper bits beyond each register width must be dropped
          write_all({4'($urandom), 16'($urandom_range(0, 3))},
                    {8'($urandom), 12'($urandom_range(0, 3))},
                    {4'($urandom), 16'($urandom_range(0, 3))},
                    {4'($urandom), 16'($urandom_range(0, 3))},
                    20'($urandom_range(0, 8)));
          write_reg(3'($urandom_range(5, 7)), 20'($urandom));
        end
        default: write_all(20'($urandom_range(0, 2)), '0, 20'($urandom_range(0, 2)),
                           20'($urandom_range(0, 2)), '0);
      endcase
      run_ticks(85);
    end

    // finish the running sequence, then start one with every wait at its maximum
    quiet = 1'b1;
    while (seq_pos != 0) send_tick(1'b0, TDATA_W'($urandom));
    s_tvalid = 1'b0;
    write_all('1, '1, '1, '1, '1);
    send_tick(1'b1, {TDATA_W{1'b1}});
    run_ticks(10);

    while (pending_lines.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/vlcd_pkg.sv
rtl/core/vlcd_digits.sv
rtl/core/voltmeter_lcd_nibble_driver_core.sv
tb/tb_voltmeter_lcd_nibble_driver_core.sv
